// File: rtl/time_of_day_seconds_clock_macros.svh
// Assertion macros used by the checker of the time-of-day clock.
`ifndef TIME_OF_DAY_SECONDS_CLOCK_MACROS_SVH
`define TIME_OF_DAY_SECONDS_CLOCK_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TODS_ASSERT_HOLDS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TODS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/tods_pkg.sv
`timescale 1ns / 1ps
// Shared constants, request codes and types of the time-of-day clock.
package tods_pkg;

    // Depth of the queue between the front end and the back end.
    localparam int unsigned QUEUE_DEPTH = 4;

    // Request codes carried in the request's tuser.
    localparam logic [2:0] REQ_SET_CHECKED = 3'd0;
    localparam logic [2:0] REQ_SET_NORM    = 3'd1;
    localparam logic [2:0] REQ_TICK_FWD    = 3'd2;
    localparam logic [2:0] REQ_TICK_BACK   = 3'd3;
    localparam logic [2:0] REQ_MOVE        = 3'd4;
    localparam logic [2:0] REQ_DIFF        = 3'd5;

    // Day arithmetic.
    localparam logic [16:0] DAY_SECONDS    = 17'd86400;
    localparam logic [16:0] LAST_SECOND    = 17'd86399;
    localparam logic [28:0] HOUR_SECONDS   = 29'd3600;
    localparam logic [22:0] MINUTE_SECONDS = 23'd60;
    localparam logic signed [15:0] MAX_HOUR   = 16'sd23;
    localparam logic signed [15:0] MAX_MINUTE = 16'sd59;

    // A multiple of a day that lifts any 32-bit signed value above zero.
    localparam logic [32:0] DAY_BIAS = 33'd2147558400;

    // A day is 128 * 675 seconds; the odd factor is reduced by reciprocal.
    localparam logic [9:0]  DAY_ODD    = 10'd675;
    localparam logic [26:0] RECIP_675  = 27'd101806632;  // floor(2^36 / 675)
    localparam int unsigned RECIP_675_SHIFT = 36;

    // Reciprocals for splitting a second count below one day.
    localparam logic [15:0] RECIP_3600 = 16'd37283;      // ceil(2^27 / 3600)
    localparam logic [18:0] RECIP_60   = 19'd279621;     // ceil(2^24 / 60)

    // One classified request handed from the front end to the back end.
    typedef struct packed {
        logic [2:0]  req;
        logic [16:0] operand;   // given time or offset, reduced into one day
        logic        bad;       // checked set or difference with an invalid time
    } tods_op_t;

    // Queue fill status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } tods_qstat_t;

endpackage

// File: rtl/time_of_day_seconds_clock.sv
`timescale 1ns / 1ps
// Top level of the time-of-day clock kept as seconds since midnight.
//
//   Channel   Direction  tdata                                      tuser
//   s_axis    in         hours, minutes, seconds, offset (80 bits)  request code (3 bits)
//   m_axis    out        hours, minutes, seconds, difference (40)   status (1 bit)
//
// One request is accepted and one result leaves per cycle when the sink is ready. The rate
// is set by the back end, which reads and rewrites the seconds counter once per queued
// request.
// Reset (aresetn low at a clock edge) empties every stage and the queue and sets the clock
// to midnight. A stalled sink freezes the back end; the queue absorbs the front end until
// it fills, and only then does s_axis_tready fall.
module time_of_day_seconds_clock import tods_pkg::*; #(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // hours_in, minutes_in, seconds_in, offset_seconds
    input  logic [2:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // hours_out, minutes_out, seconds_out, difference, zero pad
    output logic        m_axis_tuser    // status
);

    tods_qstat_t        qstat;
    tods_op_t           push_entry;
    tods_op_t           head;
    logic               push;
    logic               pop;
    logic [4:0]         hours_out;
    logic [5:0]         minutes_out;
    logic [5:0]         seconds_out;
    logic signed [17:0] difference;

    tods_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .req_type       (s_axis_tuser),
        .hours_in       ($signed(s_axis_tdata[15:0])),
        .minutes_in     ($signed(s_axis_tdata[31:16])),
        .seconds_in     ($signed(s_axis_tdata[47:32])),
        .offset_seconds ($signed(s_axis_tdata[79:48])),
        .qstat          (qstat),
        .push           (push),
        .push_entry     (push_entry)
    );

    tods_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    tods_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .qstat       (qstat),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .hours_out   (hours_out),
        .minutes_out (minutes_out),
        .seconds_out (seconds_out),
        .difference  (difference),
        .status      (m_axis_tuser)
    );

    // Result fields packed from the lowest bit up, padded to whole bytes.
    assign m_axis_tdata = {5'b0, difference, seconds_out, minutes_out, hours_out};

endmodule

// File: rtl/tods_front.sv
`timescale 1ns / 1ps
// Front end: checks each request and reduces its time or offset into one day.
module tods_front import tods_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         req_type,
    input  logic signed [15:0] hours_in,
    input  logic signed [15:0] minutes_in,
    input  logic signed [15:0] seconds_in,
    input  logic signed [31:0] offset_seconds,
    input  tods_qstat_t        qstat,
    output logic               push,
    output tods_op_t           push_entry
);

    logic [3:0]         stage_valid_reg, stage_valid_next;
    logic               adv;

    logic [2:0]         f1_req_reg, f2_req_reg, f3_req_reg;
    logic               f1_bad_reg, f2_bad_reg, f3_bad_reg;
    logic signed [28:0] f1_hprod_reg, f1_hprod_next;
    logic signed [22:0] f1_mprod_reg, f1_mprod_next;
    logic signed [15:0] f1_sec_reg;
    logic signed [31:0] f1_off_reg;
    logic               f1_bad_next;
    logic               time_ok;

    logic [32:0]        f2_u_reg, f2_u_next;
    logic [32:0]        given_ext;

    logic [52:0]        quot_prod;
    logic [16:0]        f3_q_reg, f3_q_next;
    logic [25:0]        f3_x_reg;
    logic [6:0]         f3_low_reg;

    logic [25:0]        q_times_odd;
    logic [25:0]        rem_wide;
    logic [10:0]        rem_raw;
    logic [10:0]        rem_fold;
    tods_op_t           f4_entry_reg, f4_entry_next;

    // The whole front pipeline moves unless its last entry waits on a full queue.
    assign adv              = !stage_valid_reg[3] || !qstat.full;
    assign in_ready         = adv;
    assign push             = stage_valid_reg[3] && !qstat.full;
    assign push_entry       = f4_entry_reg;
    assign stage_valid_next = {stage_valid_reg[2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= '0;
        end else if (adv) begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Stage one: range check and the scaled hour and minute terms.
    always_comb begin
        time_ok = (hours_in inside {[16'sd0 : MAX_HOUR]}) &&
                  (minutes_in inside {[16'sd0 : MAX_MINUTE]}) &&
                  (seconds_in inside {[16'sd0 : MAX_MINUTE]});
        f1_bad_next   = !time_ok && (req_type inside {REQ_SET_CHECKED, REQ_DIFF});
        f1_hprod_next = 29'(hours_in) * $signed(HOUR_SECONDS);
        f1_mprod_next = 23'(minutes_in) * $signed(MINUTE_SECONDS);
    end

    // Stage two: the signed value to reduce, lifted above zero by a whole number of days.
    always_comb begin
        given_ext = 33'(f1_hprod_reg) + 33'(f1_mprod_reg) + 33'(f1_sec_reg);
        if (f1_req_reg == REQ_MOVE) begin
            f2_u_next = 33'(f1_off_reg) + DAY_BIAS;
        end else begin
            f2_u_next = given_ext + DAY_BIAS;
        end
    end

    // Stage three: estimate the quotient of the upper bits by the odd day factor.
    always_comb begin
        quot_prod = 53'(f2_u_reg[32:7]) * 53'(RECIP_675);
        f3_q_next = quot_prod[52:RECIP_675_SHIFT];
    end

    // Stage four: remainder, corrected once because the estimate is at most one low.
    always_comb begin
        q_times_odd = 26'(f3_q_reg) * 26'(DAY_ODD);
        rem_wide    = f3_x_reg - q_times_odd;
        rem_raw     = rem_wide[10:0];
        rem_fold    = (rem_raw >= 11'(DAY_ODD)) ? (rem_raw - 11'(DAY_ODD)) : rem_raw;
        f4_entry_next.req     = f3_req_reg;
        f4_entry_next.bad     = f3_bad_reg;
        f4_entry_next.operand = {rem_fold[9:0], f3_low_reg};
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_req_reg   <= req_type;
            f1_bad_reg   <= f1_bad_next;
            f1_hprod_reg <= f1_hprod_next;
            f1_mprod_reg <= f1_mprod_next;
            f1_sec_reg   <= seconds_in;
            f1_off_reg   <= offset_seconds;

            f2_req_reg   <= f1_req_reg;
            f2_bad_reg   <= f1_bad_reg;
            f2_u_reg     <= f2_u_next;

            f3_req_reg   <= f2_req_reg;
            f3_bad_reg   <= f2_bad_reg;
            f3_q_reg     <= f3_q_next;
            f3_x_reg     <= f2_u_reg[32:7];
            f3_low_reg   <= f2_u_reg[6:0];

            f4_entry_reg <= f4_entry_next;
        end
    end

endmodule

// File: rtl/tods_queue.sv
`timescale 1ns / 1ps
// Short queue of classified requests between the front end and the back end.
module tods_queue import tods_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  tods_op_t    push_entry,
    input  logic        pop,
    output tods_op_t    head,
    output tods_qstat_t qstat
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    tods_op_t           slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    assign head        = slots_reg[rd_ptr_reg];
    assign qstat.full  = (cnt_reg == CNT_W'(DEPTH));
    assign qstat.empty = (cnt_reg == '0);

    // Pointers wrap at the depth, which need not be a power of two.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// File: rtl/tods_back.sv
`timescale 1ns / 1ps
// Back end: updates the seconds counter and splits it into hours, minutes, seconds.
module tods_back import tods_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  tods_qstat_t        qstat,
    input  tods_op_t           head,
    output logic               pop,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [4:0]         hours_out,
    output logic [5:0]         minutes_out,
    output logic [5:0]         seconds_out,
    output logic signed [17:0] difference,
    output logic               status
);

    logic [2:0]         stage_valid_reg, stage_valid_next;
    logic               adv;

    logic [16:0]        sod_reg, sod_next;
    logic [17:0]        move_sum;
    logic signed [17:0] diff_next;

    logic [16:0]        r_sod_reg;
    logic signed [17:0] r_diff_reg, c_diff_reg, o_diff_reg;
    logic               r_status_reg, c_status_reg, o_status_reg;

    logic [33:0]        hour_prod;
    logic [35:0]        min_prod;
    logic [16:0]        c_sod_reg;
    logic [4:0]         c_hours_reg, c_hours_next;
    logic [10:0]        c_tmin_reg, c_tmin_next;

    logic [16:0]        sec_wide;
    logic [10:0]        min_wide;
    logic [4:0]         o_hours_reg;
    logic [5:0]         o_minutes_reg, o_minutes_next;
    logic [5:0]         o_seconds_reg, o_seconds_next;

    // All back stages move together; the counter updates on every pop.
    assign adv              = !stage_valid_reg[2] || out_ready;
    assign pop              = !qstat.empty && adv;
    assign stage_valid_next = {stage_valid_reg[1:0], pop};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= '0;
        end else if (adv) begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // Next counter value and the difference for the request at the queue head.
    always_comb begin
        sod_next  = sod_reg;
        diff_next = '0;
        move_sum  = 18'(sod_reg) + 18'(head.operand);
        case (head.req)
            REQ_SET_CHECKED: begin
                if (!head.bad) begin
                    sod_next = head.operand;
                end
            end
            REQ_SET_NORM: begin
                sod_next = head.operand;
            end
            REQ_TICK_FWD: begin
                sod_next = (sod_reg == LAST_SECOND) ? '0 : sod_reg + 17'd1;
            end
            REQ_TICK_BACK: begin
                sod_next = (sod_reg == '0) ? LAST_SECOND : sod_reg - 17'd1;
            end
            REQ_MOVE: begin
                sod_next = (move_sum >= 18'(DAY_SECONDS)) ?
                           17'(move_sum - 18'(DAY_SECONDS)) : move_sum[16:0];
            end
            REQ_DIFF: begin
                if (!head.bad) begin
                    diff_next = $signed(18'(sod_reg) - 18'(head.operand));
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sod_reg <= '0;
        end else if (pop) begin
            sod_reg <= sod_next;
        end
    end

    // Whole hours and whole minutes of the day by reciprocal multiplication.
    always_comb begin
        hour_prod    = 34'(r_sod_reg) * 34'(RECIP_3600);
        min_prod     = 36'(r_sod_reg) * 36'(RECIP_60);
        c_hours_next = hour_prod[31:27];
        c_tmin_next  = min_prod[34:24];
    end

    // Remainders give the minute of the hour and the second of the minute.
    always_comb begin
        sec_wide       = c_sod_reg - 17'(c_tmin_reg) * 17'd60;
        min_wide       = c_tmin_reg - 11'(c_hours_reg) * 11'd60;
        o_seconds_next = sec_wide[5:0];
        o_minutes_next = min_wide[5:0];
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            r_sod_reg     <= sod_next;
            r_diff_reg    <= diff_next;
            r_status_reg  <= head.bad;

            c_sod_reg     <= r_sod_reg;
            c_hours_reg   <= c_hours_next;
            c_tmin_reg    <= c_tmin_next;
            c_diff_reg    <= r_diff_reg;
            c_status_reg  <= r_status_reg;

            o_hours_reg   <= c_hours_reg;
            o_minutes_reg <= o_minutes_next;
            o_seconds_reg <= o_seconds_next;
            o_diff_reg    <= c_diff_reg;
            o_status_reg  <= c_status_reg;
        end
    end

    assign out_valid   = stage_valid_reg[2];
    assign hours_out   = o_hours_reg;
    assign minutes_out = o_minutes_reg;
    assign seconds_out = o_seconds_reg;
    assign difference  = o_diff_reg;
    assign status      = o_status_reg;

endmodule

// File: rtl/tods_checker.sv
`timescale 1ns / 1ps
// Port checker of the time-of-day clock and its bind to the top level.
`include "time_of_day_seconds_clock_macros.svh"

module tods_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // A shown time is always a real time of day.
    `TODS_ASSERT_HOLDS(a_time_in_day, m_axis_tvalid, (m_axis_tdata[4:0] <= 5'd23) && (m_axis_tdata[10:5] <= 6'd59) && (m_axis_tdata[16:11] <= 6'd59), "result time out of range")

    // A rejected request never reports a difference.
    `TODS_ASSERT_HOLDS(a_error_no_diff, m_axis_tvalid && m_axis_tuser, m_axis_tdata[34:17] == 18'd0, "difference reported with error status")

    // The difference stays within one day either way.
    `TODS_ASSERT_HOLDS(a_diff_in_day, m_axis_tvalid, ($signed(m_axis_tdata[34:17]) <= 18'sd86399) && ($signed(m_axis_tdata[34:17]) >= -18'sd86399), "difference beyond one day")

    // Padding bits of the result stay zero.
    `TODS_ASSERT_HOLDS(a_pad_zero, m_axis_tvalid, m_axis_tdata[39:35] == 5'd0, "result padding not zero")

    // A result waiting on the sink holds still.
    `TODS_ASSERT_NEXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

endmodule

bind time_of_day_seconds_clock tods_checker u_tods_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
